// ----- hdl/ais_pkg.sv -----
// Shared constants and types for the ascending integer sorter.
package ais_pkg;

    // Number of values one set may hold
    localparam int DEPTH = 64;
    // Width of the fill count, wide enough to hold DEPTH itself
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;    // insert the broadcast word in order
        logic drain;  // shift the chain one place toward cell 0
    } cell_ctrl_t;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

endpackage : ais_pkg

// ----- hdl/ais_cell.sv -----
// One cell of the insertion chain: holds a value and its valid bit.
module ais_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ais_pkg::cell_ctrl_t          ctrl,
    input  logic signed [31:0]           in_value,
    input  logic signed [31:0]           prev_value,
    input  logic                         prev_valid,
    input  logic                         prev_gt,
    input  logic signed [31:0]           next_value,
    input  logic                         next_valid,
    output logic signed [31:0]           value,
    output logic                         valid,
    output logic                         gt
);
    import ais_pkg::*;

    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;
    logic                    valid_reg;
    logic                    valid_next;

    // Cell is empty or holds a value above the incoming word
    assign gt = !valid_reg || (in_value < value_reg);

    // Insert: take the new word at the boundary, the left neighbor above it.
    // Drain: take the right neighbor.
    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.ins && gt) begin
            if (prev_gt) begin
                value_next = prev_value;
                valid_next = prev_valid;
            end else begin
                value_next = in_value;
                valid_next = 1'b1;
            end
        end else if (ctrl.drain) begin
            value_next = next_value;
            valid_next = next_valid;
        end
    end

    // Hold payload, reset only the valid bit
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule : ais_cell

// ----- hdl/ascending_integer_sorter_top.sv -----
// Top level of the ascending integer sorter: chain of insertion cells and control.
//
//  Channel | Direction | Ports                       | Contents
//  --------+-----------+-----------------------------+-------------------------------
//  s_      | in        | tvalid tready tdata tlast   | tdata[31:0] value, tlast last_in
//  m_      | out       | tvalid tready tdata tlast   | tdata[31:0] sorted_value,
//          |           | tuser                       | tlast last_out, tuser overflow
//
// Loading takes one word per cycle; each word is placed in order across the
// whole cell row in that same cycle. The word with tlast starts the drain:
// the set of n held values leaves at one word per cycle from cell 0 as the
// row shifts. s_tready is low during the drain. Reset empties the row and
// returns to loading. A stall on m_tready freezes the row.
module ascending_integer_sorter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // [0] overflow
);
    import ais_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             drop_reg, drop_next;

    cell_ctrl_t              ctrl;
    logic signed [VAL_W-1:0] in_value;
    logic signed [VAL_W-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0]        cell_valid;
    logic [DEPTH-1:0]        cell_gt;
    logic                    s_fire, m_fire, full;

    assign in_value = s_tdata;
    assign full     = (count_reg == FULL_CNT);
    assign s_tready = (state_reg == ST_LOAD);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_DRAIN);
    assign m_fire   = m_tvalid && m_tready;

    assign ctrl.ins   = s_fire && !full;
    assign ctrl.drain = m_fire;

    // Build the cell row
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [VAL_W-1:0] prev_value, next_value;
        logic                    prev_valid, prev_gt, next_valid;

        if (i == 0) begin : g_head
            assign prev_value = in_value;
            assign prev_valid = 1'b0;
            assign prev_gt    = 1'b0;
        end else begin : g_body
            assign prev_value = cell_value[i-1];
            assign prev_valid = cell_valid[i-1];
            assign prev_gt    = cell_gt[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign next_value = cell_value[i];
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_value = cell_value[i+1];
            assign next_valid = cell_valid[i+1];
        end

        ais_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .in_value   (in_value),
            .prev_value (prev_value),
            .prev_valid (prev_valid),
            .prev_gt    (prev_gt),
            .next_value (next_value),
            .next_valid (next_valid),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .gt         (cell_gt[i])
        );
    end

    // Drive the result word from the head cell
    assign m_tdata  = cell_value[0];
    assign m_tlast  = (count_reg == ONE_CNT);
    assign m_tuser  = drop_reg;

    // Advance load / drain control
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    if (full) begin
                        drop_next = 1'b1;
                    end else begin
                        count_next = count_reg + ONE_CNT;
                    end
                    if (s_tlast) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (m_fire) begin
                    count_next = count_reg - ONE_CNT;
                    if (m_tlast) begin
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

`ifndef SYNTHESIS
    // Fill count tracks the number of occupied cells
    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cell_valid) == int'(count_reg))
        else $error("fill count differs from occupied cells");

    // Draining always has a value in the head cell
    a_drain_head: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> cell_valid[0])
        else $error("drain with empty head cell");

    // Final word leaves the row empty and returns to loading
    a_set_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_tlast) |=> (count_reg == '0 && s_tready && !drop_reg))
        else $error("row not empty after final word");

    // Head of the row stays in order: the first two occupied cells ascend
    a_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_valid[1] |-> (cell_value[0] <= cell_value[1])))
        else $error("head cells out of order");
`endif

endmodule : ascending_integer_sorter_top

// ----- bench/sorted_order_checker.sv -----
// Checker for the sorter: predicts each sorted set and compares every result word.
module sorted_order_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [ais_pkg::VAL_W-1:0] s_tdata,   // [31:0] value
    input  logic                      s_tlast,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [ais_pkg::VAL_W-1:0] m_tdata,   // [31:0] sorted_value
    input  logic                      m_tlast,
    input  logic [0:0]                m_tuser,   // [0] overflow
    output int                        fail_count,
    output int                        pending_words,
    output int                        words_checked,
    output int                        sets_closed,
    output int                        overflow_sets
);
    timeunit 1ns;
    timeprecision 1ps;
    import ais_pkg::*;

    typedef struct packed {
        logic signed [VAL_W-1:0] sorted_value;
        logic                    last_out;
        logic                    overflow;
    } sorted_word_t;

    // Predicted contents of the insertion row, kept in ascending order
    logic signed [VAL_W-1:0] held_sorted [DEPTH];
    int                      held_num;
    logic                    set_dropped;
    sorted_word_t            sorted_words_due [$];

    initial begin
        fail_count    = 0;
        pending_words = 0;
        words_checked = 0;
        sets_closed   = 0;
        overflow_sets = 0;
        held_num      = 0;
        set_dropped   = 1'b0;
    end

    // Place one incoming word in order, or drop it when the row is full;
    // on the closing word queue the whole set in ascending order.
    task automatic take_word(input logic signed [VAL_W-1:0] v, input logic closes);
        int           pos;
        sorted_word_t w;
        if (held_num < DEPTH) begin
            pos = held_num;
            while (pos > 0 && v < held_sorted[pos-1]) begin
                held_sorted[pos] = held_sorted[pos-1];
                pos--;
            end
            held_sorted[pos] = v;
            held_num++;
        end else begin
            set_dropped = 1'b1;
        end
        if (closes) begin
            for (int k = 0; k < held_num; k++) begin
                w.sorted_value = held_sorted[k];
                w.last_out     = (k == held_num - 1);
                w.overflow     = set_dropped;
                sorted_words_due.push_back(w);
            end
            sets_closed++;
            if (set_dropped)
                overflow_sets++;
            held_num    = 0;
            set_dropped = 1'b0;
        end
    endtask

    // Compare one result word against the oldest predicted word
    task automatic check_word(input logic [VAL_W-1:0] d, input logic l, input logic o);
        sorted_word_t w;
        if (sorted_words_due.size() == 0) begin
            $display("%0t: unexpected result word value=%0d last=%0b overflow=%0b",
                     $time, $signed(d), l, o);
            fail_count++;
        end else begin
            w = sorted_words_due.pop_front();
            words_checked++;
            if (w.sorted_value !== $signed(d)) begin
                $display("%0t: sorted_value expected %0d actual %0d",
                         $time, w.sorted_value, $signed(d));
                fail_count++;
            end
            if (w.last_out !== l) begin
                $display("%0t: last_out expected %0b actual %0b", $time, w.last_out, l);
                fail_count++;
            end
            if (w.overflow !== o) begin
                $display("%0t: overflow expected %0b actual %0b", $time, w.overflow, o);
                fail_count++;
            end
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            held_num    = 0;
            set_dropped = 1'b0;
            sorted_words_due.delete();
        end else begin
            if (s_tvalid && s_tready)
                take_word(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_word(m_tdata, m_tlast, m_tuser[0]);
        end
        pending_words = sorted_words_due.size();
    end

endmodule : sorted_order_checker

// ----- bench/tb_ascending_integer_sorter_top.sv -----
// Testbench top for the sorter: clock, reset, stimulus phases, watchdog and verdict.
module tb_ascending_integer_sorter_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ais_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_LEN   = 300;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [VAL_W-1:0] s_tdata  = '0;
    logic             s_tlast  = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [VAL_W-1:0] m_tdata;
    logic             m_tlast;
    logic [0:0]       m_tuser;

    int fail_count;
    int pending_words;
    int words_checked;
    int sets_closed;
    int overflow_sets;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int words_sent     = 0;
    int idle_cycles    = 0;

    always #5 aclk = ~aclk;

    ascending_integer_sorter_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    sorted_order_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_words (pending_words),
        .words_checked (words_checked),
        .sets_closed   (sets_closed),
        .overflow_sets (overflow_sets)
    );

    // Drive the receiver: random stalls, or a long hold-off when requested
    initial begin : recv_ctl
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Abort when no word moves on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired, %0d results still due", $time, pending_words);
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one word, with random idle cycles first; call at a falling edge
    task automatic send_word(input logic [VAL_W-1:0] v, input logic closes);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= closes;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        words_sent++;
    endtask

    // Bias values toward extremes and small numbers so duplicates show up
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return VAL_W'($signed($urandom_range(0, 8)) - 4);
            4:       return {VAL_W{1'b1}};
            default: return $urandom();
        endcase
    endfunction

    // Mostly short sets, some medium, a few around the capacity edge
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 6);
        else if (r < 95)
            return $urandom_range(7, 24);
        else
            return $urandom_range(DEPTH - 2, DEPTH + 2);
    endfunction

    task automatic send_random_set(input int len);
        for (int i = 0; i < len; i++)
            send_word(pick_value(), i == len - 1);
    endtask

    // Drop valid and hold until every predicted word has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_words != 0)
            @(negedge aclk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int budget);
        int n;
        int len;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        n = 0;
        while (n < budget) begin
            len = pick_len();
            send_random_set(len);
            n += len;
        end
        wait_drained();
    endtask

    initial begin : stimulus
        int total_fail;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed sets: single word, extremes, duplicates, reverse order
        send_word(32'h0000_0000, 1'b1);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'd7, 1'b0);
        send_word(-32'sd7, 1'b0);
        send_word(32'd7, 1'b0);
        send_word(32'd7, 1'b1);
        send_word(32'd3, 1'b0);
        send_word(32'd2, 1'b0);
        send_word(32'd1, 1'b0);
        send_word(32'h8000_0000, 1'b1);
        send_word(32'hAAAA_AAAA, 1'b0);
        send_word(32'h5555_5555, 1'b1);
        wait_drained();

        // Random sets under each idling pattern
        run_phase(0, 0, 20);
        run_phase(70, 0, 20);
        run_phase(0, 70, 20);
        run_phase(28, 28, 20);

        // Hold the receiver off while the sender overfills the row, closing
        // word dropped, then an exactly full set
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = HOLD_LEN;
        send_random_set(DEPTH + 2);
        send_random_set(DEPTH);

        // Pause the sender until every result is back, then one short set
        wait_drained();
        recv_stall_pct = 28;
        send_random_set(3);
        wait_drained();

        // Let any stray words surface before the verdict
        repeat (2 * DEPTH + 8) @(negedge aclk);

        $display("Sent %0d words in %0d sets (%0d overflowed); checked %0d sorted words.",
                 words_sent, sets_closed, overflow_sets, words_checked);
        $display("Covered extremes, duplicates, full and overfull sets, stalls on both sides.");
        total_fail = fail_count + pending_words;
        if (total_fail == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule : tb_ascending_integer_sorter_top
